// ===== hw/rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg: shared types and tables for the infix-to-postfix converter
// Operator codes, precedence table, result status codes and the control and
// status bundles that pass between the sequencer and the operator stack.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Stream widths.
  localparam int SYM_W  = 8;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 16;

  // Characters with a special role.
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_MOD   = 8'h25;
  localparam logic [SYM_W-1:0] CH_POW   = 8'h5E;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_POW  = 3'd5,
    OP_OPEN = 3'd6,
    OP_NONE = 3'd7
  } op_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_SYMBOL   = 3'd0,
    ST_END      = 3'd1,
    ST_END_OPEN = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_CLOSE    = 3'd4
  } status_t;

  // Requests from the sequencer to the stack.
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stack_ctl_t;

  // What the stack shows of itself.
  typedef struct packed {
    logic     empty;
    logic     full;
    op_code_t top;
  } stack_stat_t;

  function automatic op_code_t code_of(input logic [SYM_W-1:0] sym);
    op_code_t c;
    unique case (sym)
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_MOD:  c = OP_MOD;
      CH_POW:  c = OP_POW;
      CH_OPEN: c = OP_OPEN;
      default: c = OP_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] code_char(input op_code_t c);
    logic [SYM_W-1:0] ch;
    unique case (c)
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_MOD:  ch = CH_MOD;
      OP_POW:  ch = CH_POW;
      OP_OPEN: ch = CH_OPEN;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Binding strength: + - loosest, then * /, then %, then ^.
  function automatic logic [2:0] code_prec(input op_code_t c);
    logic [2:0] p;
    unique case (c)
      OP_ADD, OP_SUB: p = 3'd0;
      OP_MUL, OP_DIV: p = 3'd1;
      OP_MOD:         p = 3'd2;
      OP_POW:         p = 3'd3;
      OP_OPEN:        p = 3'd4;
      default:        p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itp_stack.sv =====
// ----------------------------------------------------------------------------
// itp_stack: operator stack
// Flip-flop array of operator codes with an occupancy count; shows the top
// entry, empty and full. One push or one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_stack (
  input  wire                  clk,
  input  wire                  rst,
  input  wire itp_pkg::stack_ctl_t ctl,
  output itp_pkg::stack_stat_t stat
);

  itp_pkg::op_code_t           mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]   count;
  logic [itp_pkg::CNT_W-1:0]   count_dec;

  assign count_dec = count - itp_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count[itp_pkg::PTR_W-1:0]] <= ctl.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + itp_pkg::CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count_dec;
    end
  end

  // The top entry is only meaningful when the stack is not empty.
  assign stat.empty = (count == '0);
  assign stat.full  = (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign stat.top   = mem[count_dec[itp_pkg::PTR_W-1:0]];

endmodule

`default_nettype wire

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix converter
// Takes one expression character per input beat and emits the postfix
// characters it releases, plus end and error beats.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)                       | tlast
//  --------+-----+------------------------------------------+------------------
//  s_*     | in  | [7:0] symbol                             | finish
//  m_*     | out | [7:0] out_symbol, [10:8] status, 0 pad   | last of the beat
//
//  A character is loaded in S_IDLE, worked on in S_SYM one stack step at a
//  time and its final result handed over in S_DONE. A skipped character or an
//  operand needs no stack step, an operator or ')' pops the operators it
//  releases one by one, and a finish then pops every stack entry in S_FLUSH
//  before the end beat. The single precedence compare against the stack top
//  sets the pace of the pop loop. The block takes a new character only when
//  the previous one is fully resolved. Reset empties the stack at once; the
//  stack contents need no clearing. A stalled output stalls the sequencer
//  only when it has a new result to hand over.
//
`default_nettype none

module infix_to_postfix_converter (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] symbol
  input  wire        s_tlast,   // finish
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // [7:0] out_symbol, [10:8] status, [15:11] zero
  output logic       m_tlast    // last beat caused by the input beat
);

  // Sequencer states: wait for a character, work on it, flush the stack on
  // finish, and hand over the last held result marked as final.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SYM   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Current input character.
  logic [itp_pkg::SYM_W-1:0] sym;
  logic                      fin;
  itp_pkg::op_code_t         code;

  // A '(' was discarded during the flush.
  logic open_seen, open_seen_next;

  // One result is held back until we know whether it is the final one for
  // this beat: it goes out unmarked when a newer result arrives and marked
  // as last when the character is resolved.
  logic                      pend_valid;
  logic [itp_pkg::SYM_W-1:0] pend_sym;
  itp_pkg::status_t          pend_status;

  itp_pkg::stack_ctl_t  sctl;
  itp_pkg::stack_stat_t sstat;

  itp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sctl),
    .stat (sstat)
  );

  // Character classes.
  logic is_skip, is_open, is_close, is_op;
  assign is_skip  = (sym == itp_pkg::CH_NUL) || (sym == itp_pkg::CH_SPACE);
  assign is_open  = (code == itp_pkg::OP_OPEN);
  assign is_close = (sym == itp_pkg::CH_CLOSE);
  assign is_op    = (code != itp_pkg::OP_OPEN) && (code != itp_pkg::OP_NONE);

  // Single compare unit: does the stack top bind tightly enough to leave
  // before the incoming operator? '^' is right-associative and pops only on
  // strictly tighter binding.
  logic [2:0] prec_top, prec_in;
  logic       top_pops;
  assign prec_top = itp_pkg::code_prec(sstat.top);
  assign prec_in  = itp_pkg::code_prec(code);
  assign top_pops = (prec_top > prec_in) ||
                    ((prec_top == prec_in) && (code != itp_pkg::OP_POW));

  logic top_is_open;
  assign top_is_open = (sstat.top == itp_pkg::OP_OPEN);

  // One step of the sequencer.
  logic                      emit;
  logic [itp_pkg::SYM_W-1:0] emit_sym;
  itp_pkg::status_t          emit_status;
  logic                      want_push, want_pop;
  state_t                    after_sym;

  assign after_sym = fin ? S_FLUSH : S_DONE;

  always_comb begin
    emit           = 1'b0;
    emit_sym       = itp_pkg::CH_NUL;
    emit_status    = itp_pkg::ST_SYMBOL;
    want_push      = 1'b0;
    want_pop       = 1'b0;
    state_next     = state;
    open_seen_next = open_seen;
    unique case (state)
      S_IDLE: begin
        open_seen_next = 1'b0;
        if (s_tvalid) begin
          state_next = S_SYM;
        end
      end
      S_SYM: begin
        priority if (is_skip) begin
          state_next = after_sym;
        end else if (is_open) begin
          if (sstat.full) begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_OVERFLOW;
          end else begin
            want_push = 1'b1;
          end
          state_next = after_sym;
        end else if (is_close) begin
          priority if (!sstat.empty && !top_is_open) begin
            emit     = 1'b1;
            emit_sym = itp_pkg::code_char(sstat.top);
            want_pop = 1'b1;
          end else if (!sstat.empty) begin
            // Matching '(' is dropped.
            want_pop   = 1'b1;
            state_next = after_sym;
          end else begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_CLOSE;
            state_next  = after_sym;
          end
        end else if (is_op) begin
          priority if (!sstat.empty && !top_is_open && top_pops) begin
            emit     = 1'b1;
            emit_sym = itp_pkg::code_char(sstat.top);
            want_pop = 1'b1;
          end else if (sstat.full) begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_OVERFLOW;
            state_next  = after_sym;
          end else begin
            want_push  = 1'b1;
            state_next = after_sym;
          end
        end else begin
          // Operand characters pass straight through.
          emit       = 1'b1;
          emit_sym   = sym;
          state_next = after_sym;
        end
      end
      S_FLUSH: begin
        if (!sstat.empty) begin
          want_pop = 1'b1;
          if (top_is_open) begin
            open_seen_next = 1'b1;
          end else begin
            emit     = 1'b1;
            emit_sym = itp_pkg::code_char(sstat.top);
          end
        end else begin
          emit        = 1'b1;
          emit_status = open_seen ? itp_pkg::ST_END_OPEN : itp_pkg::ST_END;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_valid || !m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A new result can be taken when the holding stage is free, or when the
  // held one can move on into the output register.
  logic out_free, go;
  assign out_free = !m_tvalid || m_tready;
  assign go       = !emit || !pend_valid || out_free;

  assign s_tready  = (state == S_IDLE);
  assign sctl.push = go && want_push;
  assign sctl.pop  = go && want_pop;
  assign sctl.code = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      open_seen <= 1'b0;
    end else if (go) begin
      state     <= state_next;
      open_seen <= open_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sym  <= s_tdata;
      fin  <= s_tlast;
      code <= itp_pkg::code_of(s_tdata);
    end
  end

  // Holding stage and output register.
  logic push_out, push_last;
  assign push_out  = (go && emit && pend_valid) ||
                     ((state == S_DONE) && pend_valid && out_free);
  assign push_last = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (go && emit) begin
      pend_valid <= 1'b1;
    end else if (push_out) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      pend_sym    <= emit_sym;
      pend_status <= emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      m_tdata <= {5'b0, pend_status, pend_sym};
      m_tlast <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itp_checker.sv =====
// ----------------------------------------------------------------------------
// itp_checker: port-level checks for the infix-to-postfix converter
// Watches the stream ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        m_tlast
);

  logic [2:0] st;
  assign st = m_tdata[10:8];

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // The converter works on one character at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a character is in work");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> st <= 3'(itp_pkg::ST_CLOSE))
    else $error("status code out of range");

  a_status_zero_sym: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != 3'(itp_pkg::ST_SYMBOL)) |-> m_tdata[7:0] == 8'h00)
    else $error("end or error beat carries a character");

  // The end beat closes the results of its input beat.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((st == 3'(itp_pkg::ST_END)) || (st == 3'(itp_pkg::ST_END_OPEN)))
    |-> m_tlast)
    else $error("end beat not marked last");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/infix_to_postfix_converter_checker.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_checker: postfix stream scoreboard
// Watches both stream channels of the converter, runs its own shunting-yard
// model on every accepted input beat and compares each output beat against
// the oldest postfix beat still owed.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [7:0]  s_tdata,      // [7:0] symbol
  input  wire         s_tlast,      // finish
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [15:0] m_tdata,      // [7:0] out_symbol, [10:8] status, [15:11] zero
  input  wire         m_tlast,      // last beat caused by the input beat
  output int          fail_count,
  output int          pending,
  output int          symbols_seen,
  output int          results_seen,
  output int          flags_seen
);

  typedef struct {
    logic [7:0]       sym;
    itp_pkg::status_t status;
    logic             last;
  } postfix_beat_t;

  postfix_beat_t     postfix_q[$];
  postfix_beat_t     burst_q[$];
  itp_pkg::op_code_t op_stack[itp_pkg::STACK_DEPTH];
  int                op_depth;
  int                n_fail;
  int                n_sym;
  int                n_res;
  int                n_flag;

  function automatic itp_pkg::op_code_t op_for_char(input logic [7:0] ch);
    case (ch)
      itp_pkg::CH_ADD:  return itp_pkg::OP_ADD;
      itp_pkg::CH_SUB:  return itp_pkg::OP_SUB;
      itp_pkg::CH_MUL:  return itp_pkg::OP_MUL;
      itp_pkg::CH_DIV:  return itp_pkg::OP_DIV;
      itp_pkg::CH_MOD:  return itp_pkg::OP_MOD;
      itp_pkg::CH_POW:  return itp_pkg::OP_POW;
      itp_pkg::CH_OPEN: return itp_pkg::OP_OPEN;
      default:          return itp_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] char_for_op(input itp_pkg::op_code_t op);
    case (op)
      itp_pkg::OP_ADD: return itp_pkg::CH_ADD;
      itp_pkg::OP_SUB: return itp_pkg::CH_SUB;
      itp_pkg::OP_MUL: return itp_pkg::CH_MUL;
      itp_pkg::OP_DIV: return itp_pkg::CH_DIV;
      itp_pkg::OP_MOD: return itp_pkg::CH_MOD;
      itp_pkg::OP_POW: return itp_pkg::CH_POW;
      default:         return itp_pkg::CH_NUL;
    endcase
  endfunction

  // How tightly an operator binds; '(' never reaches a compare.
  function automatic int tightness(input itp_pkg::op_code_t op);
    case (op)
      itp_pkg::OP_MUL, itp_pkg::OP_DIV: return 1;
      itp_pkg::OP_MOD:                  return 2;
      itp_pkg::OP_POW:                  return 3;
      default:                          return 0;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] sym, input itp_pkg::status_t status);
    postfix_beat_t b;
    b.sym    = sym;
    b.status = status;
    b.last   = 1'b0;
    burst_q.push_back(b);
  endfunction

  // A push into a full stack is dropped and reported as an overflow beat.
  function automatic void push_operator(input itp_pkg::op_code_t op);
    if (op_depth >= itp_pkg::STACK_DEPTH) begin
      emit(itp_pkg::CH_NUL, itp_pkg::ST_OVERFLOW);
    end else begin
      op_stack[op_depth] = op;
      op_depth++;
    end
  endfunction

  task automatic predict_postfix(input logic [7:0] sym, input logic fin);
    itp_pkg::op_code_t code;
    itp_pkg::op_code_t top;
    logic              held;
    logic              saw_open;
    code = op_for_char(sym);
    burst_q.delete();
    if (sym == itp_pkg::CH_NUL || sym == itp_pkg::CH_SPACE) begin
      // Skipped character; only the finish flag can still act.
    end else if (code == itp_pkg::OP_OPEN) begin
      push_operator(code);
    end else if (sym == itp_pkg::CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::OP_OPEN) begin
        emit(char_for_op(op_stack[op_depth-1]), itp_pkg::ST_SYMBOL);
        op_depth--;
      end
      if (op_depth > 0) begin
        op_depth--;
      end else begin
        emit(itp_pkg::CH_NUL, itp_pkg::ST_CLOSE);
      end
    end else if (code != itp_pkg::OP_NONE) begin
      // Equal binding pops too, except for the right-associative power.
      held = 1'b0;
      while (!held && op_depth > 0 && op_stack[op_depth-1] != itp_pkg::OP_OPEN) begin
        top = op_stack[op_depth-1];
        if (tightness(top) > tightness(code) ||
            (tightness(top) == tightness(code) && code != itp_pkg::OP_POW)) begin
          emit(char_for_op(top), itp_pkg::ST_SYMBOL);
          op_depth--;
        end else begin
          held = 1'b1;
        end
      end
      push_operator(code);
    end else begin
      emit(sym, itp_pkg::ST_SYMBOL);
    end
    if (fin) begin
      saw_open = 1'b0;
      while (op_depth > 0) begin
        top = op_stack[op_depth-1];
        if (top == itp_pkg::OP_OPEN) begin
          saw_open = 1'b1;
        end else begin
          emit(char_for_op(top), itp_pkg::ST_SYMBOL);
        end
        op_depth--;
      end
      emit(itp_pkg::CH_NUL, saw_open ? itp_pkg::ST_END_OPEN : itp_pkg::ST_END);
    end
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size()-1].last = 1'b1;
    end
    foreach (burst_q[i]) begin
      postfix_q.push_back(burst_q[i]);
    end
  endtask

  initial begin
    n_fail = 0;
    n_sym  = 0;
    n_res  = 0;
    n_flag = 0;
    op_depth = 0;
  end

  always @(posedge clk) begin
    postfix_beat_t exp_beat;
    if (rst) begin
      postfix_q.delete();
      op_depth = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_res++;
        if (postfix_q.size() == 0) begin
          $error("unexpected output beat: out_symbol %h, status %0d, last %b",
                 m_tdata[7:0], m_tdata[10:8], m_tlast);
          n_fail++;
        end else begin
          exp_beat = postfix_q.pop_front();
          if (exp_beat.status != itp_pkg::ST_SYMBOL) n_flag++;
          if (m_tdata[7:0] !== exp_beat.sym) begin
            $error("out_symbol mismatch: expected %h, actual %h", exp_beat.sym, m_tdata[7:0]);
            n_fail++;
          end
          if (m_tdata[10:8] !== exp_beat.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_beat.status,
                   m_tdata[10:8]);
            n_fail++;
          end
          if (m_tlast !== exp_beat.last) begin
            $error("last mismatch: expected %b, actual %b", exp_beat.last, m_tlast);
            n_fail++;
          end
          if (m_tdata[15:11] !== 5'd0) begin
            $error("pad mismatch: expected 0, actual %h", m_tdata[15:11]);
            n_fail++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        n_sym++;
        predict_postfix(s_tdata, s_tlast);
      end
    end
    fail_count   <= n_fail;
    pending      <= postfix_q.size();
    symbols_seen <= n_sym;
    results_seen <= n_res;
    flags_seen   <= n_flag;
  end

endmodule

// ===== verif/infix_to_postfix_converter_tb.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb: stream test of the infix-to-postfix converter
// Feeds hand-picked expressions, a stack overflow run and random expressions
// into the converter under random idling on both channels; a checker beside
// the block predicts every postfix beat and this top gives the verdict.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

  // Cycles with no beat on either channel before the run is declared hung.
  // The slowest legal silence is a flush that discards a full stack of '('
  // entries.
  localparam int IDLE_LIMIT   = 2000;
  localparam int ITEM_TARGET  = 130;
  // Random expressions begun within this many characters of the target run with both sides always ready.
  localparam int CALM_TAIL    = 25;
  localparam int DRAIN_CYCLES = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         m_tlast;

  // Idling switch shared by the sender and the receiver.
  logic        idle_on = 1'b1;
  int          stall_left = 0;
  int          sent_count = 0;

  int          fail_count;
  int          pending;
  int          symbols_seen;
  int          results_seen;
  int          flags_seen;

  // Characters of one expression before they are sent.
  logic [7:0]  expr_q[$];

  // Operators first, so that the first six entries can be drawn as operators.
  logic [7:0]  specials[10] = '{
    itp_pkg::CH_ADD, itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV,
    itp_pkg::CH_MOD, itp_pkg::CH_POW, itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE,
    itp_pkg::CH_SPACE, itp_pkg::CH_NUL
  };

  // Opening beats as {finish, symbol}. They hit every operator, equal binding
  // (left-associative pops), chained power (right-associative, no pop), a
  // skipped space inside parentheses, the top symbol value, a close with no
  // open that first pops an operator, a finish on a NUL character, and a
  // finish that discards an open parenthesis left on the stack.
  logic [8:0]  opening_beats[25] = '{
    {1'b0, "a"}, {1'b0, itp_pkg::CH_ADD}, {1'b0, "b"}, {1'b0, itp_pkg::CH_MUL},
    {1'b0, "c"}, {1'b0, itp_pkg::CH_SUB}, {1'b0, "d"}, {1'b0, itp_pkg::CH_DIV},
    {1'b0, "e"}, {1'b0, itp_pkg::CH_MOD}, {1'b0, "f"}, {1'b0, itp_pkg::CH_POW},
    {1'b0, "g"}, {1'b0, itp_pkg::CH_POW}, {1'b1, "h"},
    {1'b0, itp_pkg::CH_OPEN}, {1'b0, itp_pkg::CH_SPACE}, {1'b0, 8'hFF},
    {1'b0, itp_pkg::CH_CLOSE}, {1'b0, itp_pkg::CH_ADD}, {1'b0, itp_pkg::CH_CLOSE},
    {1'b1, itp_pkg::CH_NUL},
    {1'b0, itp_pkg::CH_OPEN}, {1'b0, itp_pkg::CH_MUL}, {1'b1, 8'h80}
  };

  infix_to_postfix_converter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  infix_to_postfix_converter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .symbols_seen (symbols_seen),
    .results_seen (results_seen),
    .flags_seen   (flags_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: when idling is on, the output is stalled in random bursts;
  // otherwise it is always ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Watchdog: a run that goes quiet on both channels for too long has hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Presents one input beat and returns at the edge that accepts it. An
  // optional gap with valid low may come first. Valid is only ever written
  // once per edge, so back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] sym, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // Sends the queued expression; the finish flag, if asked for, rides on its final beat.
  task automatic send_run(input logic close_out);
    foreach (expr_q[i]) begin
      send_beat(expr_q[i], close_out && (i == expr_q.size() - 1));
    end
  endtask

  // Operands come from letters, digits and the upper half of the byte range,
  // none of which is an operator, a parenthesis, a space or NUL.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h80 + 8'($urandom_range(0, 127));
    endcase
  endfunction

  // Builds a well-formed expression with random operands, operators and
  // nesting. A broken one either leaves a '(' unclosed or adds a stray ')'.
  task automatic build_expression(input logic broken);
    int   terms;
    int   opens;
    logic want_operand;
    expr_q.delete();
    terms        = $urandom_range(1, 6);
    opens        = 0;
    want_operand = 1'b1;
    while (terms > 0) begin
      if (want_operand) begin
        if (opens < 4 && $urandom_range(0, 4) == 0) begin
          expr_q.push_back(itp_pkg::CH_OPEN);
          opens++;
        end else begin
          if ($urandom_range(0, 5) == 0) expr_q.push_back(itp_pkg::CH_SPACE);
          expr_q.push_back(pick_operand());
          want_operand = 1'b0;
          terms--;
        end
      end else if (opens > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(itp_pkg::CH_CLOSE);
        opens--;
      end else begin
        expr_q.push_back(specials[$urandom_range(0, 5)]);
        want_operand = 1'b1;
      end
    end
    if (broken) begin
      if (opens > 0 && $urandom_range(0, 1) == 0) begin
        opens--;
      end else begin
        expr_q.push_back(itp_pkg::CH_CLOSE);
      end
    end
    repeat (opens) expr_q.push_back(itp_pkg::CH_CLOSE);
  endtask

  initial begin
    int kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Hand-picked expressions.
    foreach (opening_beats[i]) begin
      send_beat(opening_beats[i][7:0], opening_beats[i][8]);
    end

    // Fill the stack with '(' entries, then overflow it with one more '(' and
    // with a power operator. The close removes one open and the finish on a
    // space flushes the rest, ending with an unmatched-open end beat.
    repeat (itp_pkg::STACK_DEPTH + 1) send_beat(itp_pkg::CH_OPEN, 1'b0);
    send_beat(itp_pkg::CH_POW, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(itp_pkg::CH_CLOSE, 1'b0);
    send_beat(itp_pkg::CH_SPACE, 1'b1);

    // Random expressions: mostly well formed, some broken, some noise. About
    // a quarter run with no idling, and so does the tail of the run.
    while (sent_count < ITEM_TARGET) begin
      idle_on = (sent_count < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        expr_q.delete();
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 1) == 0) begin
            expr_q.push_back(specials[$urandom_range(0, 9)]);
          end else begin
            expr_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_run(1'($urandom_range(0, 1)));
      end else begin
        build_expression(kind == 1);
        send_run(1'b1);
      end
    end
    s_tvalid <= 1'b0;
    idle_on = 1'b0;

    // The last accepted beat is only predicted at the edge that accepted it,
    // so give the checker one edge before trusting the pending count.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters: operators, parentheses, operands, skipped ones,",
             symbols_seen);
    $display("  overflow and broken runs; checked %0d postfix beats, %0d end or error.",
             results_seen, flags_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== infix_to_postfix_converter.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_stack.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/itp_checker.sv
verif/infix_to_postfix_converter_checker.sv
verif/infix_to_postfix_converter_tb.sv
